FILE: rtl/mpm_pkg.sv
// shared types, constants and reply-string rom for the pattern response matcher
package mpm_pkg;

    // command codes
    localparam logic [1:0] CMD_DATA   = 2'd0;
    localparam logic [1:0] CMD_ARM    = 2'd1;
    localparam logic [1:0] CMD_DISARM = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam int PATTERN_COUNT = 12;
    localparam int CAPTURE_LEN   = 28;
    localparam int ROM_TEXT_W    = 128;

    localparam logic [7:0]  NO_DATA     = 8'h26;
    localparam logic [7:0]  NEWLINE     = 8'h0A;
    localparam logic [11:0] ARMED_RESET = 12'd3074;

    // input beat
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] pattern_index;
        logic [7:0] data_byte;
    } mpm_in_t;

    // result beat
    typedef struct packed {
        logic [11:0] complete_mask;
        logic        capture_valid;
        logic [7:0]  capture_byte;
        logic [4:0]  capture_pos;
        logic        capture_last;
    } mpm_out_t;

    // decoded operation for the current beat, already qualified by advance
    typedef struct packed {
        logic       data;
        logic       arm;
        logic       disarm;
        logic       clear;
        logic [3:0] index;
        logic [7:0] data_byte;
    } mpm_op_t;

    // per-matcher status
    typedef struct packed {
        logic done;
        logic complete;
    } mpm_lane_t;

    // capture result for the current beat
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [4:0] pos;
        logic       last;
    } mpm_cap_t;

    // reply strings, right-aligned: first character in the highest used byte, last in the bottom byte
    function automatic logic [ROM_TEXT_W-1:0] rom_string(input logic [3:0] row);
        logic [ROM_TEXT_W-1:0] s;
        case (row)
            4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd9: s = ROM_TEXT_W'("OK");
            4'd1:    s = ROM_TEXT_W'("GOT IP");
            4'd6:    s = ROM_TEXT_W'("+IPD");
            4'd7:    s = ROM_TEXT_W'(">");
            4'd10:   s = ROM_TEXT_W'("WIFI DISCONNECT");
            4'd11:   s = ROM_TEXT_W'("#Uart#");
            default: s = '0;
        endcase
        return s;
    endfunction

    // unclamped string lengths
    function automatic logic [4:0] rom_len_raw(input logic [3:0] row);
        logic [4:0] n;
        case (row)
            4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd9: n = 5'd2;
            4'd1:    n = 5'd6;
            4'd6:    n = 5'd4;
            4'd7:    n = 5'd1;
            4'd10:   n = 5'd15;
            4'd11:   n = 5'd6;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // character at a column of a string, zero past its end
    function automatic logic [7:0] rom_char(input logic [3:0] row, input logic [4:0] col);
        logic [ROM_TEXT_W-1:0] s;
        logic [4:0]            n;
        logic [4:0]            back;
        logic [7:0]            sh;
        s    = rom_string(row);
        n    = rom_len_raw(row);
        back = n - 5'd1 - col;
        sh   = {back, 3'b000};
        if (col >= n) begin
            return 8'h00;
        end
        return 8'(s >> sh);
    endfunction

endpackage

FILE: rtl/mpm_lane.sv
// one reply matcher: armed flag, match counter and byte compare
module mpm_lane #(
    parameter int IDX     = 0,
    parameter int MAX_LEN = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mpm_pkg::mpm_op_t  op,
    output mpm_pkg::mpm_lane_t status
);
    import mpm_pkg::*;

    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int RAW_LEN = int'(rom_len_raw(4'(IDX)));
    localparam int LEN     = (RAW_LEN > MAX_LEN) ? MAX_LEN : RAW_LEN;
    localparam logic [CNT_W-1:0] LEN_C = CNT_W'(LEN);

    logic             armed_reg, armed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [4:0]       col;
    logic [7:0]       expect_char;
    logic             addressed;
    logic             active;
    logic             hit;
    logic             done;

    // character expected at the current count
    assign col         = 5'(count_reg);
    assign expect_char = rom_char(4'(IDX), col);
    assign addressed   = (op.index == 4'(IDX));
    assign active      = armed_reg && (count_reg < LEN_C);
    assign hit         = (op.data_byte == expect_char);

    // counter and armed flag update
    always_comb
    begin
        armed_next = armed_reg;
        count_next = count_reg;
        done       = 1'b0;
        if (op.data && active)
        begin
            if (hit)
            begin
                count_next = count_reg + CNT_W'(1);
                done       = (count_next == LEN_C);
            end
            else
            begin
                count_next = '0;
            end
        end
        else if (addressed && op.arm)
        begin
            armed_next = 1'b1;
        end
        else if (addressed && op.disarm)
        begin
            armed_next = 1'b0;
            count_next = '0;
        end
        else if (addressed && op.clear)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= ARMED_RESET[IDX];
            count_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            count_reg <= count_next;
        end
    end

    assign status.done     = done;
    assign status.complete = (count_next == LEN_C);

endmodule

FILE: rtl/mpm_capture.sv
// line capture that starts on a completion and ends at newline or full length
module mpm_capture (
    input  logic             clk,
    input  logic             rst_n,
    input  mpm_pkg::mpm_op_t op,
    input  logic             start,
    output mpm_pkg::mpm_cap_t cap
);
    import mpm_pkg::*;

    logic       capturing_reg, capturing_next;
    logic [4:0] count_reg, count_next;
    logic       take;
    logic [4:0] pos;
    logic [4:0] pos_inc;
    logic       last;

    // a completion restarts the capture at position zero
    assign take    = op.data && (start || capturing_reg);
    assign pos     = start ? 5'd0 : count_reg;
    assign pos_inc = pos + 5'd1;
    assign last    = (pos_inc >= 5'(CAPTURE_LEN)) || (op.data_byte == NEWLINE);

    always_comb
    begin
        capturing_next = capturing_reg;
        count_next     = count_reg;
        if (take)
        begin
            capturing_next = !last;
            count_next     = last ? 5'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            count_reg     <= 5'd0;
        end
        else
        begin
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
        end
    end

    // fields read zero when nothing is stored
    assign cap.valid = take;
    assign cap.data  = take ? op.data_byte : 8'h00;
    assign cap.pos   = take ? pos : 5'd0;
    assign cap.last  = take && last;

endmodule

FILE: rtl/multi_pattern_response_matcher.sv
// A beat accepted into the input register moves into the result register when the result stage advances.
// Throughput: one beat per cycle unless the result stalls; the matchers compare
// against the rom in parallel in the single stage between input and result registers.
// A stalled result beat holds the result register; the input register takes
// at most one more beat and then stalls the input until the result moves.
// Reset (rst_n low, asynchronous) empties both stages, clears counters and capture.
module multi_pattern_response_matcher #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  mpm_pkg::mpm_in_t cmd_beat,
    output logic             res_valid,
    input  logic             res_stall,
    output mpm_pkg::mpm_out_t res_beat
);
    import mpm_pkg::*;

    logic      in_valid_reg;
    mpm_in_t   in_reg;
    logic      res_valid_reg;
    mpm_out_t  res_reg;
    mpm_out_t  res_next;
    logic      adv;
    logic      go;
    mpm_op_t   op;
    mpm_lane_t lane_stat [PATTERN_COUNT];
    logic [PATTERN_COUNT-1:0] done_vec;
    logic [PATTERN_COUNT-1:0] complete_vec;
    mpm_cap_t  cap;

    // pipeline control
    assign adv       = !res_valid_reg || !res_stall;
    assign go        = in_valid_reg && adv;
    assign cmd_stall = in_valid_reg && !adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            in_reg <= cmd_beat;
        end
    end

    // decode the held beat
    assign op.data      = go && (in_reg.command == CMD_DATA) && (in_reg.data_byte != NO_DATA);
    assign op.arm       = go && (in_reg.command == CMD_ARM);
    assign op.disarm    = go && (in_reg.command == CMD_DISARM);
    assign op.clear     = go && (in_reg.command == CMD_CLEAR);
    assign op.index     = in_reg.pattern_index;
    assign op.data_byte = in_reg.data_byte;

    // matcher lanes
    for (genvar i = 0; i < PATTERN_COUNT; i++)
    begin : g_lane
        mpm_lane #(
            .IDX     (i),
            .MAX_LEN (MAX_PATTERN_LEN)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .op     (op),
            .status (lane_stat[i])
        );
        assign done_vec[i]     = lane_stat[i].done;
        assign complete_vec[i] = lane_stat[i].complete;
    end

    mpm_capture u_capture (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .start (|done_vec),
        .cap   (cap)
    );

    // result assembly
    assign res_next.complete_mask = complete_vec;
    assign res_next.capture_valid = cap.valid;
    assign res_next.capture_byte  = cap.data;
    assign res_next.capture_pos   = cap.pos;
    assign res_next.capture_last  = cap.last;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_reg;

endmodule

FILE: rtl/mpm_checker.sv
// port-level checks for the pattern response matcher, bound to the top level
module mpm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_stall,
    input mpm_pkg::mpm_out_t res_beat
);
    import mpm_pkg::*;

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_beat))
        else $error("result beat changed while stalled");

    // capture fields are zero when no byte was stored
    a_cap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_beat.capture_valid |->
            res_beat.capture_byte == 8'h00 && res_beat.capture_pos == 5'd0
            && !res_beat.capture_last)
        else $error("capture fields set without a stored byte");

    // capture position stays inside the buffer
    a_cap_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_beat.capture_valid |-> res_beat.capture_pos < 5'(CAPTURE_LEN))
        else $error("capture position past buffer end");

    // an early end of capture only happens on a newline
    a_cap_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_beat.capture_last
            && res_beat.capture_pos != 5'(CAPTURE_LEN - 1) |->
            res_beat.capture_byte == NEWLINE)
        else $error("capture ended early without newline");

endmodule

bind multi_pattern_response_matcher mpm_checker u_mpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat)
);
